/* design/iec_frame_byte_receiver_defines.svh */
// Assertion macros for the frame byte receiver.
// Included by ifr_back, the RTL file that carries concurrent checks; no other dependencies.
`ifndef IEC_FRAME_BYTE_RECEIVER_DEFINES_SVH
`define IEC_FRAME_BYTE_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that an expression holds at every clock edge out of reset.
`define IFR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("%m: invariant violated");
// Check that a condition implies a consequence in the same cycle.
`define IFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication violated");
// Check that a condition implies a consequence in the next cycle.
`define IFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");
`else
`define IFR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define IFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/ifr_pkg.sv */
// Shared types and constants for the frame byte receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package ifr_pkg;

    // Protocol control characters
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Channel code that names no source
    localparam logic [1:0] CHANNEL_NONE = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED_MODE = 4'd1;

    // Stream widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 3;

    // Which start characters a byte matches
    typedef struct packed {
        logic soh;
        logic nak;
        logic ack;
        logic slash;
    } start_class_t;

    // Item as decoded by the front end
    typedef struct packed {
        logic         cmd;
        logic [1:0]   channel;
        logic [7:0]   rx_byte;
        logic         ch_valid;
        start_class_t start;
        logic         is_lf;
        logic         is_term;
    } item_class_t;

    // Configuration register contents
    typedef struct packed {
        logic rx_enable;
        logic connected_mode;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       accepted;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       frame_done;
        logic [1:0] owner_out;
        logic [7:0] frames_seen;
        logic       overflow;
    } result_t;

endpackage

`default_nettype wire

/* design/ifr_front.sv */
// Front end: decodes an incoming item into its character classes.
// Depends on ifr_pkg.
`default_nettype none

module ifr_front (
    input  wire logic               cmd,
    input  wire logic [1:0]         channel,
    input  wire logic [7:0]         rx_byte,
    output ifr_pkg::item_class_t    item
);
    import ifr_pkg::*;

    // Classify the byte and the source channel
    always_comb begin
        item.cmd         = cmd;
        item.channel     = channel;
        item.rx_byte     = rx_byte;
        item.ch_valid    = (channel != CHANNEL_NONE);
        item.start.soh   = (rx_byte == CH_SOH);
        item.start.nak   = (rx_byte == CH_NAK);
        item.start.ack   = (rx_byte == CH_ACK);
        item.start.slash = (rx_byte == CH_SLASH);
        item.is_lf       = (rx_byte == CH_LF);
        item.is_term     = (rx_byte == CH_ETX) || (rx_byte == CH_EOT);
    end

endmodule

`default_nettype wire

/* design/ifr_queue.sv */
// Two-entry queue of decoded items between front end and back end.
// Depends on ifr_pkg.
`default_nettype none

module ifr_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ifr_pkg::item_class_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ifr_pkg::item_class_t    out_item
);
    import ifr_pkg::*;

    item_class_t entries_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* design/ifr_back.sv */
// Back end: frame state, acceptance decision and the output register.
// Depends on ifr_pkg and iec_frame_byte_receiver_defines.svh.
`default_nettype none
`include "iec_frame_byte_receiver_defines.svh"

module ifr_back #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ifr_pkg::cfg_t        cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ifr_pkg::item_class_t in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ifr_pkg::result_t          out_res
);
    import ifr_pkg::*;

    localparam int unsigned PTR_W = $clog2(BUF_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(BUF_DEPTH);
    localparam logic [PTR_W-1:0] PTR_TWO  = PTR_W'(2);

    logic [PTR_W-1:0] wp_reg, wp_next;
    start_class_t     first_reg, first_next;
    logic             prev_term_reg, prev_term_next;
    logic [1:0]       owner_reg, owner_next;
    logic [7:0]       frames_reg, frames_next;
    logic             held_reg, held_next;
    logic             out_valid_reg;
    result_t          res_reg, res_next;
    logic             pop;
    logic             heard;
    logic             start_ok;
    logic             done;
    start_class_t     first;

    assign in_ready  = !out_valid_reg || out_ready;
    assign pop       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Decide what the head item does to the frame state
    always_comb begin
        wp_next        = wp_reg;
        first_next     = first_reg;
        prev_term_next = prev_term_reg;
        owner_next     = owner_reg;
        frames_next    = frames_reg;
        held_next      = held_reg;
        res_next       = '0;
        done           = 1'b0;
        heard          = cfg.rx_enable && in_item.ch_valid && !held_reg &&
                         !(cfg.connected_mode && (in_item.channel != owner_reg));
        first          = (wp_reg == '0) ? in_item.start : first_reg;
        start_ok       = cfg.connected_mode ? (first.soh || first.nak || first.ack)
                                            : (first.slash || first.ack);
        if (in_item.cmd) begin
            // Release the held frame and rewind
            held_next = 1'b0;
            wp_next   = '0;
        end else if (heard) begin
            if (wp_reg >= PTR_FULL) begin
                res_next.overflow = 1'b1;
            end else if (!start_ok) begin
                wp_next = '0;
            end else begin
                if (cfg.connected_mode) begin
                    done = ((wp_reg == '0) && (first.nak || first.ack)) ||
                           ((wp_reg >= PTR_TWO) && prev_term_reg);
                end else begin
                    done = (wp_reg != '0) && in_item.is_lf;
                end
                res_next.accepted    = 1'b1;
                res_next.store_index = 8'(wp_reg);
                res_next.store_byte  = in_item.rx_byte;
                res_next.frame_done  = done;
                if (wp_reg == '0) begin
                    first_next = in_item.start;
                end
                prev_term_next = in_item.is_term;
                wp_next        = wp_reg + PTR_W'(1);
                if (done) begin
                    owner_next  = in_item.channel;
                    frames_next = frames_reg + 8'd1;
                    held_next   = 1'b1;
                end
            end
        end
        res_next.owner_out   = owner_next;
        res_next.frames_seen = frames_next;
    end

    // Commit state on pop; drop the output when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            first_reg     <= '0;
            prev_term_reg <= 1'b0;
            owner_reg     <= 2'd0;
            frames_reg    <= 8'd0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            wp_reg        <= wp_next;
            first_reg     <= first_next;
            prev_term_reg <= prev_term_next;
            owner_reg     <= owner_next;
            frames_reg    <= frames_next;
            held_reg      <= held_next;
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

    `IFR_ASSERT_ALWAYS(a_ptr_bound, aclk, aresetn, wp_reg <= PTR_FULL)
    `IFR_ASSERT_IMPL(a_done_holds, aclk, aresetn, out_valid_reg && res_reg.frame_done, held_reg)
    `IFR_ASSERT_IMPL(a_ovf_full, aclk, aresetn, out_valid_reg && res_reg.overflow, wp_reg == PTR_FULL)
    `IFR_ASSERT_NEXT(a_release_clears, aclk, aresetn, pop && in_item.cmd, (wp_reg == '0) && !held_reg)

endmodule

`default_nettype wire

/* design/iec_frame_byte_receiver.sv */
// Frame byte receiver: stream input, two-entry item queue, frame state back end.
// Top level; depends on ifr_pkg, ifr_front, ifr_queue and ifr_back.
//
// Usage:
//   Received bytes and release commands enter on the s_ stream channel; every
//   item yields exactly one result item on the m_ stream channel, carrying the
//   store position and byte, the frame-complete mark (m_tlast), link owner,
//   frame count and the accepted, timer-restart and overflow flags.
//   Registers rx_enable and connected_mode are written on the cfg_ channel,
//   which is always ready; write them only while no item is in flight.
//   An accepted item is written into a queue slot and then, once the back end
//   takes it, into the output register that drives m_tvalid and the result.
//   Throughput: one item per cycle while m_tready stays high, as the back end
//   reads one queue entry each cycle; a low m_tready stalls it.
//   Reset (aresetn low, synchronous) clears the frame pointer, owner, counter
//   and hold flag, sets rx_enable to 1 and connected_mode to 0; no clearing
//   pass follows, so items are taken from the first cycle out of reset.
//   When m_tready stays low the output register holds its item, the queue
//   fills with up to two more items and then s_tready drops.
`default_nettype none

module iec_frame_byte_receiver #(
    parameter int unsigned BUF_DEPTH = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input item stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ifr_pkg::S_TDATA_W-1:0]     s_tdata,  // [1:0] channel, [9:2] rx_byte
    input  wire logic                              s_tuser,  // [0] cmd
    // Result item stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ifr_pkg::M_TDATA_W-1:0]          m_tdata,  // [7:0] store_index,
                                                              // [15:8] store_byte,
                                                              // [17:16] owner_out,
                                                              // [25:18] frames_seen
    output logic [ifr_pkg::M_TUSER_W-1:0]          m_tuser,  // [0] accepted,
                                                              // [1] restart_timer, [2] overflow
    output logic                                   m_tlast,  // frame_done
    // Configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ifr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic                              cfg_wdata
);
    import ifr_pkg::*;

    cfg_t        cfg_reg;
    item_class_t front_item;
    item_class_t queue_item;
    logic        queue_valid;
    logic        back_ready;
    result_t     res;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rx_enable      <= 1'b1;
            cfg_reg.connected_mode <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RX_ENABLE:      cfg_reg.rx_enable      <= cfg_wdata;
                CFG_CONNECTED_MODE: cfg_reg.connected_mode <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Decode the incoming item
    ifr_front u_front (
        .cmd     (s_tuser),
        .channel (s_tdata[1:0]),
        .rx_byte (s_tdata[9:2]),
        .item    (front_item)
    );

    // Buffer decoded items
    ifr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_item  (queue_item)
    );

    // Run the frame state machine
    ifr_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result item
    assign m_tdata = {6'd0, res.frames_seen, res.owner_out, res.store_byte, res.store_index};
    assign m_tuser = {res.overflow, res.accepted, res.accepted};
    assign m_tlast = res.frame_done;

endmodule

`default_nettype wire
